>>> rtl/lrg_pkg.sv
// Package for the Lehmer random generator: generator constants, action codes
// and the digit product helper. No dependencies.
`default_nettype none
package lrg_pkg;

  localparam int ValueW = 31;
  localparam int SeedW  = 32;
  localparam int FracW  = 32;
  localparam int DigitW = 4;
  localparam int DigitCount = SeedW / DigitW;
  localparam int DigitProdW = 19;

  localparam logic [ValueW-1:0] LcgM = 31'h7FFF_FFFF;
  localparam logic [14:0] LcgA = 15'd16807;
  localparam logic [SeedW-1:0] ZeroSeed = 32'h1234_5987;

  localparam logic [1:0] ACT_DRAW_WORD  = 2'd0;
  localparam logic [1:0] ACT_DRAW_STORE = 2'd1;
  localparam logic [1:0] ACT_ADVANCE    = 2'd2;
  localparam logic [1:0] ACT_LOAD       = 2'd3;

  function automatic logic [DigitProdW-1:0] digit_prod(input logic [DigitW-1:0] d);
    logic [DigitProdW-1:0] p;
    p = DigitProdW'(d) * DigitProdW'(LcgA);
    return p;
  endfunction

endpackage
`default_nettype wire

>>> rtl/lrg_modmul.sv
// Digit-serial multiply of a seed by 16807 modulo 2^31-1, four bits a cycle.
// Depends on lrg_pkg.
`default_nettype none
module lrg_modmul (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [lrg_pkg::ValueW-1:0] seed,
  output logic                           done,
  output logic [lrg_pkg::ValueW-1:0]     result
);
  import lrg_pkg::*;

  localparam int CntW = $clog2(DigitCount);

  logic [SeedW-1:0]  seed_r, seed_nxt;
  logic [ValueW-1:0] acc_r, acc_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [ValueW-1:0] rot;
  logic [ValueW:0]   sum;

  always_comb begin
    rot = {acc_r[ValueW-DigitW-1:0], acc_r[ValueW-1:ValueW-DigitW]};
    sum = {1'b0, rot} + (ValueW+1)'(digit_prod(seed_r[SeedW-1:SeedW-DigitW]));
    if (sum >= {1'b0, LcgM}) begin
      sum = sum - {1'b0, LcgM};
    end
  end

  always_comb begin
    seed_nxt = seed_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      seed_nxt = {1'b0, seed};
      acc_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      seed_nxt = {seed_r[SeedW-DigitW-1:0], {DigitW{1'b0}}};
      acc_nxt  = sum[ValueW-1:0];
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CntW'(DigitCount - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seed_r <= seed_nxt;
    acc_r  <= acc_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule
`default_nettype wire

>>> rtl/lrg_norm.sv
// Serial normalizer that turns a 31-bit value into the IEEE single bits of
// value / 2^31 with round to nearest even. Depends on lrg_pkg.
`default_nettype none
module lrg_norm (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [lrg_pkg::ValueW-1:0] value,
  input  wire logic                      ack,
  output logic                           done,
  output logic [lrg_pkg::FracW-1:0]      frac
);
  import lrg_pkg::*;

  localparam int PosW = $clog2(ValueW);

  logic [ValueW-1:0] n_r, n_nxt;
  logic [PosW-1:0]   p_r, p_nxt;
  logic              busy_r, busy_nxt;

  logic              is_zero;
  logic              rnd;
  logic [24:0]       m25;
  logic [7:0]        expo;
  logic [22:0]       mant;

  assign is_zero = (n_r == '0);
  assign done    = busy_r && (n_r[ValueW-1] || is_zero);

  always_comb begin
    n_nxt    = n_r;
    p_nxt    = p_r;
    busy_nxt = busy_r;
    if (start) begin
      n_nxt    = value;
      p_nxt    = PosW'(ValueW - 1);
      busy_nxt = 1'b1;
    end else if (done) begin
      if (ack) begin
        busy_nxt = 1'b0;
      end
    end else if (busy_r) begin
      if (n_r[ValueW-1:ValueW-4] == 4'd0) begin
        n_nxt = {n_r[ValueW-5:0], 4'd0};
        p_nxt = p_r - PosW'(4);
      end else begin
        n_nxt = {n_r[ValueW-2:0], 1'b0};
        p_nxt = p_r - PosW'(1);
      end
    end
  end

  always_comb begin
    rnd = n_r[6] && ((n_r[5:0] != 6'd0) || n_r[7]);
    m25 = {1'b0, n_r[ValueW-1:7]} + 25'(rnd);
    if (m25[24]) begin
      mant = m25[23:1];
      expo = 8'(p_r) + 8'd97;
    end else begin
      mant = m25[22:0];
      expo = 8'(p_r) + 8'd96;
    end
    if (is_zero) begin
      frac = '0;
    end else begin
      frac = {1'b0, expo, mant};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt;
    p_r <= p_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/lehmer_random_generator.sv
// Top level of the Lehmer random generator: seed store, control and output
// register. Depends on lrg_pkg, lrg_modmul and lrg_norm.
// A draw passes the eight 4-bit digit steps of the modular multiply and then
// the normalize shifter of the fraction unit before it shows on out_tvalid.
// One beat is in work at a time, so a draw holds the input until its result
// is taken into the output register, which waits on any output stall; a load
// beat gives no output. Synchronous reset clears the stored seed to zero and
// empties the output register.
`default_nettype none
module lehmer_random_generator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // action[1:0], seed_word[33:2], zero fill
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata   // random_value[30:0], fraction_bits[62:31], zero fill
);
  import lrg_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_NORM = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [1:0]        action_r, action_nxt;
  logic [SeedW-1:0]  stored_r, stored_nxt;
  logic [ValueW-1:0] val_r, val_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [63:0]       out_data_r, out_data_nxt;

  logic [1:0]        in_action;
  logic [SeedW-1:0]  in_word;
  logic [SeedW-1:0]  src;
  logic [SeedW-1:0]  wrapped;
  logic [ValueW-1:0] prep;
  logic              in_fire;
  logic              mul_start;
  logic              mul_done;
  logic [ValueW-1:0] mul_result;
  logic              norm_start;
  logic              norm_done;
  logic              norm_ack;
  logic [FracW-1:0]  norm_frac;
  logic              out_free;

  assign in_action = in_tdata[1:0];
  assign in_word   = in_tdata[33:2];
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    src     = (in_action == ACT_DRAW_WORD) ? in_word : stored_r;
    wrapped = src + {1'b0, LcgM};
    if (!src[SeedW-1]) begin
      if (src == '0) begin
        prep = ZeroSeed[ValueW-1:0];
      end else if (src[ValueW-1:0] == LcgM) begin
        prep = '0;
      end else begin
        prep = src[ValueW-1:0];
      end
    end else begin
      if (wrapped == '1) begin
        prep = LcgM - ValueW'(1);
      end else if (wrapped == '0) begin
        prep = ZeroSeed[ValueW-1:0];
      end else begin
        prep = wrapped[ValueW-1:0];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    action_nxt    = action_r;
    stored_nxt    = stored_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mul_start     = 1'b0;
    norm_start    = 1'b0;
    norm_ack      = 1'b0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_action == ACT_LOAD) begin
            stored_nxt = in_word;
          end else begin
            action_nxt = in_action;
            mul_start  = 1'b1;
            state_nxt  = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          if (action_r == ACT_ADVANCE) begin
            stored_nxt = {1'b0, mul_result};
          end
          val_nxt    = mul_result;
          norm_start = 1'b1;
          state_nxt  = ST_NORM;
        end
      end
      ST_NORM: begin
        if (norm_done && out_free) begin
          norm_ack      = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, norm_frac, val_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  lrg_modmul u_modmul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .seed   (prep),
    .done   (mul_done),
    .result (mul_result)
  );

  lrg_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .value (mul_result),
    .ack   (norm_ack),
    .done  (norm_done),
    .frac  (norm_frac)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stored_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stored_r    <= stored_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r   <= action_nxt;
    val_r      <= val_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire
